### rtl/core/owrs_pkg.sv
// Package for the 1-Wire ROM search unit.
// Holds the item codes, status codes, register map and field widths.
// Used by onewire_rom_search_unit; depends on nothing else.
package owrs_pkg;

    localparam int ROM_BITS_DEFAULT = 64;
    localparam int FUNC_W           = 2;
    localparam int STATUS_W         = 3;
    localparam int COUNT_W          = 8;
    localparam int POS_W            = 6;
    localparam int ADDR_W           = 3;
    localparam int DATA_W           = 32;

    localparam logic [COUNT_W-1:0] MAX_DEVICES_RESET = 8'd8;
    localparam logic [COUNT_W-1:0] COUNT_SATURATED   = 8'hFF;

    // Register index, taken from paddr above the byte offset.
    typedef enum logic [0:0] {
        REG_MAX_DEVICES = 1'b0
    } reg_index_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RESTART  = 2'd0,
        FUNC_PASS     = 2'd1,
        FUNC_BIT_PAIR = 2'd2,
        FUNC_UNUSED   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_FOUND  = 3'd1,
        ST_DONE   = 3'd2,
        ST_NOPRES = 3'd3,
        ST_NORESP = 3'd4,
        ST_LIMIT  = 3'd5
    } status_t;

endpackage

### rtl/core/onewire_rom_search_unit.sv
// Top level of the 1-Wire ROM search unit: search state, bit-pair decision
// and the result register with its handshake. Depends on owrs_pkg.
//
// Each transaction on the s_ channel (restart, pass start or bit pair) yields
// exactly one result transaction on the m_ channel, from the result register
// loaded when it is accepted. The decision for a bit pair compares the bit
// index against the last discrepancy and updates one bit of the ROM register,
// so the unit takes one transaction per clock cycle while m_ready is high; the
// result register frees up in the same cycle it is taken, so s_ready stays high.
// The only register, max_devices, sits at byte address 0 of the APB port and
// should be written while no transaction is outstanding.
module onewire_rom_search_unit
    import owrs_pkg::*;
#(
    parameter int ROM_BITS = ROM_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // Input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic                s_presence,
    input  logic                s_id_bit,
    input  logic                s_id_bit_complement,
    // Result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_write_bit,
    output logic [STATUS_W-1:0] m_status,
    output logic [ROM_BITS-1:0] m_rom_id,
    output logic [COUNT_W-1:0]  m_device_count,
    output logic [POS_W-1:0]    m_bit_position
);

    localparam int CNT_W  = $clog2(ROM_BITS);
    localparam int DISC_W = $clog2(ROM_BITS + 1);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(ROM_BITS - 1);

    logic [COUNT_W-1:0]  max_devices_reg;
    logic [ROM_BITS-1:0] rom_bits_reg, rom_bits_next;
    logic [DISC_W-1:0]   last_disc_reg, last_disc_next;
    logic [DISC_W-1:0]   pass_disc_reg, pass_disc_next;
    logic [CNT_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [COUNT_W-1:0]  found_cnt_reg, found_cnt_next;
    logic                finished_reg, finished_next;
    logic                active_reg, active_next;

    logic                m_valid_reg;
    logic                write_bit_reg, write_bit_next;
    status_t             status_reg, status_next;
    logic [ROM_BITS-1:0] rom_id_reg, rom_id_next;
    logic [COUNT_W-1:0]  dev_cnt_reg;
    logic [POS_W-1:0]    bit_pos_reg, bit_pos_next;

    logic                in_xfer;
    logic                cfg_write;
    logic                cfg_sel;
    logic [DISC_W-1:0]   bit_num;
    logic                dir_bit;
    func_t               func;

    // APB: zero wait states, single register.
    assign pready    = 1'b1;
    assign cfg_sel   = (reg_index_t'(paddr[ADDR_W-1]) == REG_MAX_DEVICES);
    assign cfg_write = psel && penable && pwrite && cfg_sel;
    assign prdata    = cfg_sel ? DATA_W'(max_devices_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_devices_reg <= MAX_DEVICES_RESET;
        end else if (cfg_write) begin
            max_devices_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // The result register frees itself in the cycle its transaction is taken.
    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;
    assign func    = func_t'(s_func);
    assign bit_num = DISC_W'(bit_cnt_reg) + DISC_W'(1);

    always_comb begin
        rom_bits_next  = rom_bits_reg;
        last_disc_next = last_disc_reg;
        pass_disc_next = pass_disc_reg;
        bit_cnt_next   = bit_cnt_reg;
        found_cnt_next = found_cnt_reg;
        finished_next  = finished_reg;
        active_next    = active_reg;
        write_bit_next = 1'b0;
        status_next    = ST_OK;
        rom_id_next    = '0;
        bit_pos_next   = '0;
        dir_bit        = s_id_bit;

        unique case (func)
            FUNC_RESTART: begin
                rom_bits_next  = '0;
                last_disc_next = '0;
                pass_disc_next = '0;
                bit_cnt_next   = '0;
                found_cnt_next = '0;
                finished_next  = 1'b0;
                active_next    = 1'b0;
            end
            FUNC_PASS: begin
                // The device limit is checked ahead of completion.
                priority if (found_cnt_reg >= max_devices_reg) begin
                    status_next = ST_LIMIT;
                end else if (finished_reg) begin
                    status_next = ST_DONE;
                end else if (!s_presence) begin
                    last_disc_next = '0;
                    active_next    = 1'b0;
                    status_next    = ST_NOPRES;
                end else begin
                    active_next    = 1'b1;
                    bit_cnt_next   = '0;
                    pass_disc_next = '0;
                end
            end
            FUNC_BIT_PAIR: begin
                if (active_reg) begin
                    bit_pos_next = POS_W'(bit_cnt_reg);
                    if (s_id_bit && s_id_bit_complement) begin
                        last_disc_next = '0;
                        active_next    = 1'b0;
                        bit_cnt_next   = '0;
                        status_next    = ST_NORESP;
                    end else begin
                        // Both slots zero means devices disagree at this bit.
                        if (!s_id_bit && !s_id_bit_complement) begin
                            priority if (bit_num == last_disc_reg) begin
                                dir_bit = 1'b1;
                            end else if (bit_num > last_disc_reg) begin
                                dir_bit        = 1'b0;
                                pass_disc_next = bit_num;
                            end else begin
                                dir_bit = rom_bits_reg[bit_cnt_reg];
                                if (!dir_bit) begin
                                    pass_disc_next = bit_num;
                                end
                            end
                        end
                        rom_bits_next[bit_cnt_reg] = dir_bit;
                        write_bit_next             = dir_bit;
                        if (bit_cnt_reg == LAST_POS) begin
                            last_disc_next = pass_disc_next;
                            if (pass_disc_next == '0) begin
                                finished_next = 1'b1;
                            end
                            if (found_cnt_reg != COUNT_SATURATED) begin
                                found_cnt_next = found_cnt_reg + COUNT_W'(1);
                            end
                            rom_id_next  = rom_bits_next;
                            status_next  = ST_FOUND;
                            active_next  = 1'b0;
                            bit_cnt_next = '0;
                        end else begin
                            bit_cnt_next = bit_cnt_reg + CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                // The unused code changes nothing and reports ok.
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bits_reg  <= '0;
            last_disc_reg <= '0;
            pass_disc_reg <= '0;
            bit_cnt_reg   <= '0;
            found_cnt_reg <= '0;
            finished_reg  <= 1'b0;
            active_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (in_xfer) begin
                rom_bits_reg  <= rom_bits_next;
                last_disc_reg <= last_disc_next;
                pass_disc_reg <= pass_disc_next;
                bit_cnt_reg   <= bit_cnt_next;
                found_cnt_reg <= found_cnt_next;
                finished_reg  <= finished_next;
                active_reg    <= active_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            write_bit_reg <= write_bit_next;
            status_reg    <= status_next;
            rom_id_reg    <= rom_id_next;
            dev_cnt_reg   <= found_cnt_next;
            bit_pos_reg   <= bit_pos_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_write_bit    = write_bit_reg;
    assign m_status       = status_reg;
    assign m_rom_id       = rom_id_reg;
    assign m_device_count = dev_cnt_reg;
    assign m_bit_position = bit_pos_reg;

endmodule

### tb/sv/tb_onewire_rom_search_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for onewire_rom_search_unit: emulates a bus of 1-Wire devices,
// predicts every result transaction and checks it against the m_ channel.
// Depends on owrs_pkg and the onewire_rom_search_unit RTL.
module tb_onewire_rom_search_unit;
    import owrs_pkg::*;

    localparam int ROM_W          = ROM_BITS_DEFAULT;
    localparam int BUS_MAX        = 6;
    localparam int ITEM_TARGET    = 1450;
    localparam int PHASES         = 5;
    localparam int HOLD_AT        = 600;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam logic [ADDR_W-1:0] MAX_DEV_ADDR = ADDR_W'(4 * int'(REG_MAX_DEVICES));

    typedef struct {
        bit                 write_bit;
        status_t            status;
        logic [ROM_W-1:0]   rom_id;
        logic [COUNT_W-1:0] device_count;
        logic [POS_W-1:0]   bit_position;
    } step_outcome_t;

    // Tracks the search state, predicts each result and compares it on arrival.
    class search_tracker;
        bit [7:0]         max_devices;
        logic [ROM_W-1:0] rom_acc;
        bit [6:0]         last_disc;
        bit [6:0]         pass_disc;
        bit [POS_W-1:0]   bit_pos;
        bit [COUNT_W-1:0] found_count;
        bit               finished;
        bit               pass_active;
        step_outcome_t    outcomes_due[$];
        int unsigned      accepted;
        int unsigned      mismatches;
        int unsigned      status_hits[6];
        int unsigned      settings_used;

        function new();
            max_devices = MAX_DEVICES_RESET;
            settings_used = 1;
            clear_search();
        endfunction

        function void clear_search();
            rom_acc = '0;
            last_disc = '0;
            pass_disc = '0;
            bit_pos = '0;
            found_count = '0;
            finished = 1'b0;
            pass_active = 1'b0;
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        // Applies one accepted input transaction and queues the outcome it must produce.
        function step_outcome_t take_item(func_t f, bit pres, bit idb, bit idc);
            step_outcome_t r;
            bit [6:0] n;
            bit dir;
            r.write_bit = 1'b0;
            r.status = ST_OK;
            r.rom_id = '0;
            r.bit_position = '0;
            case (f)
                FUNC_RESTART: clear_search();
                FUNC_PASS: begin
                    if (found_count >= max_devices) begin
                        r.status = ST_LIMIT;
                    end else if (finished) begin
                        r.status = ST_DONE;
                    end else if (!pres) begin
                        last_disc = '0;
                        pass_active = 1'b0;
                        r.status = ST_NOPRES;
                    end else begin
                        pass_active = 1'b1;
                        bit_pos = '0;
                        pass_disc = '0;
                    end
                end
                FUNC_BIT_PAIR: begin
                    if (pass_active) begin
                        r.bit_position = bit_pos;
                        n = 7'(bit_pos) + 7'd1;
                        if (idb && idc) begin
                            last_disc = '0;
                            pass_active = 1'b0;
                            bit_pos = '0;
                            r.status = ST_NORESP;
                        end else begin
                            // Both slots zero: devices disagree, follow the discrepancy rule.
                            if (!idb && !idc) begin
                                if (n == last_disc) begin
                                    dir = 1'b1;
                                end else if (n > last_disc) begin
                                    dir = 1'b0;
                                    pass_disc = n;
                                end else begin
                                    dir = rom_acc[bit_pos];
                                    if (!dir)
                                        pass_disc = n;
                                end
                            end else begin
                                dir = idb;
                            end
                            rom_acc[bit_pos] = dir;
                            r.write_bit = dir;
                            if (int'(n) >= ROM_W) begin
                                last_disc = pass_disc;
                                if (last_disc == 0)
                                    finished = 1'b1;
                                if (found_count != COUNT_SATURATED)
                                    found_count++;
                                r.rom_id = rom_acc;
                                r.status = ST_FOUND;
                                pass_active = 1'b0;
                                bit_pos = '0;
                            end else begin
                                bit_pos = n[POS_W-1:0];
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.device_count = found_count;
            outcomes_due.push_back(r);
            accepted++;
            status_hits[int'(r.status)]++;
            return r;
        endfunction

        function void check_result(logic wb, logic [STATUS_W-1:0] st, logic [ROM_W-1:0] rom,
                                   logic [COUNT_W-1:0] cnt, logic [POS_W-1:0] pos);
            step_outcome_t e;
            if (outcomes_due.size() == 0) begin
                flag($sformatf("result transaction with none outstanding, status %0d", st));
                return;
            end
            e = outcomes_due.pop_front();
            if (wb !== e.write_bit || st !== e.status || rom !== e.rom_id
                    || cnt !== e.device_count || pos !== e.bit_position)
                flag($sformatf({"exp wb %0b st %0d rom %h cnt %0d pos %0d / ",
                                "got wb %0b st %0d rom %h cnt %0d pos %0d"},
                               e.write_bit, e.status, e.rom_id, e.device_count,
                               e.bit_position, wb, st, rom, cnt, pos));
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic [FUNC_W-1:0]   s_func;
    logic                s_presence;
    logic                s_id_bit;
    logic                s_id_bit_complement;
    logic                m_valid;
    logic                m_ready;
    logic                m_write_bit;
    logic [STATUS_W-1:0] m_status;
    logic [ROM_W-1:0]    m_rom_id;
    logic [COUNT_W-1:0]  m_device_count;
    logic [POS_W-1:0]    m_bit_position;

    search_tracker sb = new();

    // Emulated devices on the wire and which of them still follow the current pass.
    logic [ROM_W-1:0] dev_rom [BUS_MAX];
    bit               dev_on  [BUS_MAX];
    int unsigned      n_dev;
    int unsigned      valid_idle_pct;
    int unsigned      ready_stall_pct;
    int unsigned      quiet_cycles;

    onewire_rom_search_unit #(
        .ROM_BITS(ROM_W)
    ) u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_func              (s_func),
        .s_presence          (s_presence),
        .s_id_bit            (s_id_bit),
        .s_id_bit_complement (s_id_bit_complement),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_write_bit         (m_write_bit),
        .m_status            (m_status),
        .m_rom_id            (m_rom_id),
        .m_device_count      (m_device_count),
        .m_bit_position      (m_bit_position)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, sb.outcomes_due.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stalls, plus one long hold-off so the unit backs up its input.
    initial begin : result_sink
        bit held_once;
        held_once = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_write_bit, m_status, m_rom_id, m_device_count,
                                m_bit_position);
            if (!held_once && sb.accepted >= HOLD_AT) begin
                held_once = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (ready_stall_pct != 0 && $urandom_range(0, 99) < ready_stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic drive_item(func_t f, bit pres, bit idb, bit idc, output step_outcome_t r);
        if (valid_idle_pct != 0 && $urandom_range(0, 99) < valid_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_presence <= pres;
        s_id_bit <= idb;
        s_id_bit_complement <= idc;
        do @(posedge aclk); while (!s_ready);
        r = sb.take_item(f, pres, idb, idc);
    endtask

    task automatic write_max_devices(bit [7:0] val);
        logic [DATA_W-1:0] rd;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MAX_DEV_ADDR;
        pwdata <= DATA_W'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // Read the register back in the next transfer.
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        sb.max_devices = val;
        sb.settings_used++;
        if (rd[7:0] !== val)
            sb.flag($sformatf("max_devices reads back %h, wrote %h", rd[7:0], val));
    endtask

    task automatic build_bus();
        logic [ROM_W-1:0] base;
        logic [ROM_W-1:0] tail_mask;
        int unsigned split;
        int unsigned pick;
        n_dev = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, BUS_MAX);
        pick = $urandom_range(0, 9);
        case (pick)
            0: base = '0;
            1: base = '1;
            default: base = ROM_W'({$urandom, $urandom});
        endcase
        // Devices share a random-length prefix so discrepancies land deep in the ROM.
        for (int i = 0; i < n_dev; i++) begin
            split = $urandom_range(0, ROM_W - 1);
            tail_mask = ~((ROM_W'(1) << split) - ROM_W'(1));
            dev_rom[i] = (base & ~tail_mask) | (ROM_W'({$urandom, $urandom}) & tail_mask);
        end
        if (pick < 2 && n_dev != 0)
            dev_rom[0] = base;
    endtask

    task automatic run_pass();
        step_outcome_t r;
        int unsigned p;
        bit any0;
        bit any1;
        for (int i = 0; i < BUS_MAX; i++)
            dev_on[i] = (i < n_dev);
        drive_item(FUNC_PASS, n_dev != 0 && $urandom_range(0, 19) != 0,
                   1'($urandom), 1'($urandom), r);
        while (sb.pass_active) begin
            if ($urandom_range(0, 199) == 0) begin
                // A stray transaction breaks the pass; the next pass start recovers.
                drive_item(func_t'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                           1'($urandom), r);
                break;
            end
            if ($urandom_range(0, 299) == 0) begin
                for (int i = 0; i < BUS_MAX; i++)
                    dev_on[i] = 1'b0;
            end
            p = sb.bit_pos;
            any0 = 1'b0;
            any1 = 1'b0;
            for (int i = 0; i < n_dev; i++) begin
                if (dev_on[i]) begin
                    if (dev_rom[i][p])
                        any1 = 1'b1;
                    else
                        any0 = 1'b1;
                end
            end
            // Wired-AND bus: a slot reads low if any device drives a zero.
            drive_item(FUNC_BIT_PAIR, 1'($urandom), !any0, !any1, r);
            for (int i = 0; i < n_dev; i++) begin
                if (dev_on[i] && dev_rom[i][p] != r.write_bit)
                    dev_on[i] = 1'b0;
            end
        end
    endtask

    task automatic run_search(int unsigned budget);
        step_outcome_t r;
        int unsigned passes;
        build_bus();
        drive_item(FUNC_RESTART, 1'($urandom), 1'($urandom), 1'($urandom), r);
        passes = 0;
        while (passes < 10 && !sb.finished && sb.found_count < sb.max_devices
                && sb.accepted < budget) begin
            run_pass();
            passes++;
            if (n_dev == 0 && passes >= 2)
                break;
        end
        // One more pass start, to run into completion or the device limit if either was reached.
        drive_item(FUNC_PASS, 1'($urandom), 1'($urandom), 1'($urandom), r);
    endtask

    initial begin : stimulus
        step_outcome_t r;
        int unsigned budget;
        bit [7:0] setting;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_func = FUNC_RESTART;
        s_presence = 1'b0;
        s_id_bit = 1'b0;
        s_id_bit_complement = 1'b0;
        quiet_cycles = 0;
        valid_idle_pct = 0;
        ready_stall_pct = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: ignored selectors, no presence, all four bit-pair patterns,
        // no response, restart and pass start in the middle of a pass.
        drive_item(FUNC_UNUSED, 1'b1, 1'b1, 1'b1, r);
        drive_item(FUNC_BIT_PAIR, 1'b0, 1'b0, 1'b0, r);
        drive_item(FUNC_PASS, 1'b0, 1'b0, 1'b0, r);
        drive_item(FUNC_PASS, 1'b1, 1'b0, 1'b0, r);
        drive_item(FUNC_BIT_PAIR, 1'b0, 1'b1, 1'b0, r);
        drive_item(FUNC_BIT_PAIR, 1'b1, 1'b0, 1'b1, r);
        drive_item(FUNC_BIT_PAIR, 1'b0, 1'b0, 1'b0, r);
        drive_item(FUNC_BIT_PAIR, 1'b0, 1'b1, 1'b1, r);
        drive_item(FUNC_BIT_PAIR, 1'b1, 1'b0, 1'b0, r);
        drive_item(FUNC_PASS, 1'b1, 1'b1, 1'b0, r);
        drive_item(FUNC_BIT_PAIR, 1'b0, 1'b0, 1'b0, r);
        drive_item(FUNC_RESTART, 1'b1, 1'b1, 1'b1, r);
        drive_item(FUNC_BIT_PAIR, 1'b1, 1'b1, 1'b0, r);
        drive_item(FUNC_PASS, 1'b1, 1'b1, 1'b1, r);
        drive_item(FUNC_PASS, 1'b0, 1'b0, 1'b1, r);
        drive_item(FUNC_UNUSED, 1'b0, 1'b0, 1'b0, r);
        drive_item(FUNC_RESTART, 1'b0, 1'b0, 1'b0, r);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: setting = 8'd255;
                1: setting = 8'd1;
                2: setting = 8'd2;
                3: setting = 8'($urandom_range(3, 254));
                default: setting = MAX_DEVICES_RESET;
            endcase
            s_valid <= 1'b0;
            while (sb.outcomes_due.size() != 0) @(posedge aclk);
            repeat (2) @(posedge aclk);
            write_max_devices(setting);
            budget = sb.accepted + (ITEM_TARGET - sb.accepted) / (PHASES - ph);
            while (sb.accepted < budget) begin
                if (ph == PHASES - 1) begin
                    valid_idle_pct = 0;
                    ready_stall_pct = 0;
                end else begin
                    valid_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 20);
                    ready_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 20);
                end
                run_search(budget);
            end
        end

        s_valid <= 1'b0;
        while (sb.outcomes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d transactions over %0d max_devices settings, %0d mismatches",
                 sb.accepted, sb.settings_used, sb.mismatches);
        $display("statuses: ok %0d found %0d done %0d no-presence %0d no-response %0d limit %0d",
                 sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
                 sb.status_hits[3], sb.status_hits[4], sb.status_hits[5]);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
rtl/core/owrs_pkg.sv
rtl/core/onewire_rom_search_unit.sv
tb/sv/tb_onewire_rom_search_unit.sv
